FILE: sv/enma_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// enma_pkg
// Shared constants for the centered moving-average smoother.
// ----------------------------------------------------------------------------
package enma_pkg;

    localparam int CHANNELS_DEF   = 4;
    localparam int MAX_WINDOW_DEF = 32;
    localparam int SAMPLE_W       = 16;
    localparam int CHAN_W         = 2;
    localparam int CFG_W          = 6;
    localparam int QUEUE_DEPTH    = 4;

endpackage

FILE: sv/enma_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// enma_front
// Accepts samples, keeps per-channel history and window sums, and emits
// (sum, count) jobs for each result into the job queue.
// ----------------------------------------------------------------------------
module enma_front
    import enma_pkg::*;
#(
    parameter int CHANNELS   = CHANNELS_DEF,
    parameter int MAX_WINDOW = MAX_WINDOW_DEF,
    parameter int TOT_W      = SAMPLE_W + $clog2(MAX_WINDOW + 1),
    parameter int CNT_W      = $clog2(MAX_WINDOW + 1)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic [CHAN_W-1:0]          i_channel,
    input  logic                       i_end_of_sequence,
    input  logic                       i_cfg_valid,
    input  logic [CFG_W-1:0]           i_cfg_data,
    output logic                       o_push,
    output logic [TOT_W-1:0]           o_job_sum,
    output logic [CNT_W-1:0]           o_job_count,
    output logic [CHAN_W-1:0]          o_job_channel,
    output logic                       o_job_last,
    input  logic                       i_full
);

    localparam int SLOT_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CI_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int DEPTH    = CHANNELS * MAX_WINDOW;
    localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW2      = CNT_W + 1;

    typedef enum logic [2:0] {S_IDLE, S_OLD_RD, S_UPD, S_LOOP, S_SUB} t_state;

    t_state                   r_state;
    logic signed [TOT_W-1:0]  r_total [CHANNELS];
    logic [SLOT_W-1:0]        r_slot  [CHANNELS];
    logic [CNT_W-1:0]         r_seen  [CHANNELS];
    logic [CNT_W-1:0]         r_w;
    logic signed [SAMPLE_W-1:0] r_x;
    logic [CHAN_W-1:0]        r_ch;
    logic                     r_eos;
    logic signed [TOT_W-1:0]  r_tot;
    logic [CNT_W-1:0]         r_cnt;
    logic [CNT_W-1:0]         r_seen_w;
    logic [SLOT_W-1:0]        r_cur;
    logic [CNT_W-1:0]         r_d;
    logic [CNT_W-1:0]         r_last;

    logic signed [SAMPLE_W-1:0] mem [DEPTH];
    logic signed [SAMPLE_W-1:0] r_rdata;

    logic [CI_W-1:0]          ci;
    logic [CNT_W-1:0]         h, lag;
    logic [SLOT_W-1:0]        cur;
    logic [CNT_W-1:0]         seen_old, seen_new, cnt_new, first;
    logic signed [TOT_W-1:0]  old_sub, tot_new;
    logic                     skip;
    logic [SW2-1:0]           target;
    logic                     trim;
    logic [SLOT_W-1:0]        rd_slot;
    logic [ADDR_W-1:0]        base, raddr, waddr;
    logic                     we;

    function automatic logic [SLOT_W-1:0] slot_back(input logic [SLOT_W-1:0] c,
                                                    input logic [CNT_W-1:0] b);
        logic [SW2-1:0] t;
        t = SW2'(c) + SW2'(MAX_WINDOW) - SW2'(b);
        if (t >= SW2'(MAX_WINDOW)) begin
            t = t - SW2'(MAX_WINDOW);
        end
        return SLOT_W'(t);
    endfunction

    assign ci       = CI_W'(r_ch);
    assign h        = r_w >> 1;
    assign lag      = r_w - CNT_W'(1) - h;
    assign cur      = r_slot[ci];
    assign seen_old = r_seen[ci];
    assign old_sub  = (seen_old >= r_w) ? TOT_W'(r_rdata) : '0;
    assign tot_new  = r_total[ci] - old_sub + TOT_W'(r_x);
    assign seen_new = (seen_old == CNT_W'(MAX_WINDOW)) ? seen_old : seen_old + CNT_W'(1);
    assign cnt_new  = (seen_new < r_w) ? seen_new : r_w;
    assign first    = (lag < seen_new) ? lag : seen_new - CNT_W'(1);
    assign skip     = !r_eos && (lag >= seen_new);

    assign target = ((SW2'(r_d) + SW2'(h) + SW2'(1)) < SW2'(r_seen_w))
                  ? (SW2'(r_d) + SW2'(h) + SW2'(1)) : SW2'(r_seen_w);
    assign trim   = SW2'(r_cnt) > target;

    assign base    = ADDR_W'(ci) * ADDR_W'(MAX_WINDOW);
    assign rd_slot = (r_state == S_LOOP) ? slot_back(r_cur, r_cnt - CNT_W'(1))
                                         : slot_back(cur, r_w);
    assign raddr   = base + ADDR_W'(rd_slot);
    assign waddr   = base + ADDR_W'(cur);
    assign we      = (r_state == S_UPD);

    assign o_stall       = (r_state != S_IDLE);
    assign o_push        = (r_state == S_LOOP) && !trim && !i_full;
    assign o_job_sum     = r_tot;
    assign o_job_count   = r_cnt;
    assign o_job_channel = r_ch;
    assign o_job_last    = r_eos && (r_d == '0);

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= r_x;
        end
        r_rdata <= mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_w     <= CNT_W'(1);
            for (int c = 0; c < CHANNELS; c++) begin
                r_total[c] <= '0;
                r_slot[c]  <= '0;
                r_seen[c]  <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_data == '0) begin
                    r_w <= CNT_W'(1);
                end else if (int'(i_cfg_data) > MAX_WINDOW) begin
                    r_w <= CNT_W'(MAX_WINDOW);
                end else begin
                    r_w <= CNT_W'(i_cfg_data);
                end
                for (int c = 0; c < CHANNELS; c++) begin
                    r_total[c] <= '0;
                    r_slot[c]  <= '0;
                    r_seen[c]  <= '0;
                end
            end
            unique case (r_state)
                S_IDLE: begin
                    r_x   <= i_sample;
                    r_ch  <= i_channel;
                    r_eos <= i_end_of_sequence;
                    if (i_valid && (int'(i_channel) < CHANNELS)) begin
                        r_state <= S_OLD_RD;
                    end
                end
                S_OLD_RD: begin
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    r_tot    <= tot_new;
                    r_cnt    <= cnt_new;
                    r_seen_w <= seen_new;
                    r_cur    <= cur;
                    r_d      <= first;
                    r_last   <= r_eos ? '0 : lag;
                    if (r_eos) begin
                        r_total[ci] <= '0;
                        r_slot[ci]  <= '0;
                        r_seen[ci]  <= '0;
                    end else begin
                        r_total[ci] <= tot_new;
                        r_slot[ci]  <= (cur == SLOT_W'(MAX_WINDOW - 1)) ? '0
                                                                        : cur + SLOT_W'(1);
                        r_seen[ci]  <= seen_new;
                    end
                    r_state <= skip ? S_IDLE : S_LOOP;
                end
                S_LOOP: begin
                    if (trim) begin
                        r_state <= S_SUB;
                    end else if (!i_full) begin
                        if (r_d == r_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_d <= r_d - CNT_W'(1);
                        end
                    end
                end
                S_SUB: begin
                    r_tot   <= r_tot - TOT_W'(r_rdata);
                    r_cnt   <= r_cnt - CNT_W'(1);
                    r_state <= S_LOOP;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: sv/enma_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// enma_queue
// Small FIFO of pending division jobs between front and back.
// ----------------------------------------------------------------------------
module enma_queue
    import enma_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    logic [WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wp, r_rp;
    logic [PTR_W:0]   r_cnt;

    assign o_full  = (r_cnt == (PTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + PTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + PTR_W'(1);
            end
            r_cnt <= r_cnt + (PTR_W+1)'(i_push) - (PTR_W+1)'(i_pop);
        end
    end

endmodule

FILE: sv/enma_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// enma_back
// Bit-serial restoring divider: rounded sum/count, ties away from zero,
// with a registered output beat.
// ----------------------------------------------------------------------------
module enma_back
    import enma_pkg::*;
#(
    parameter int TOT_W = 22,
    parameter int CNT_W = 6
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_empty,
    output logic                       o_pop,
    input  logic [TOT_W-1:0]           i_sum,
    input  logic [CNT_W-1:0]           i_count,
    input  logic [CHAN_W-1:0]          i_channel,
    input  logic                       i_last,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic signed [SAMPLE_W-1:0] o_smoothed,
    output logic [CHAN_W-1:0]          o_out_channel,
    output logic                       o_last_of_sequence
);

    localparam int BIT_W = $clog2(TOT_W);

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_HOLD} t_state;

    t_state             r_state;
    logic [TOT_W-1:0]   r_num;
    logic [CNT_W-1:0]   r_den;
    logic [CNT_W-1:0]   r_rem;
    logic [BIT_W-1:0]   r_bits;
    logic               r_neg;

    logic [TOT_W-1:0]   mag;
    logic [CNT_W:0]     rem_sh;
    logic               ge;
    logic [TOT_W-1:0]   q;

    assign mag    = i_sum[TOT_W-1] ? (TOT_W'(0) - i_sum) : i_sum;
    assign rem_sh = {r_rem, r_num[TOT_W-1]};
    assign ge     = rem_sh >= {1'b0, r_den};
    assign q      = {r_num[TOT_W-2:0], ge};
    assign o_pop  = (r_state == S_IDLE) && !i_empty;
    assign o_valid = (r_state == S_HOLD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_num  <= mag + TOT_W'(i_count >> 1);
                    r_den  <= i_count;
                    r_rem  <= '0;
                    r_bits <= BIT_W'(TOT_W - 1);
                    r_neg  <= i_sum[TOT_W-1];
                    o_out_channel      <= i_channel;
                    o_last_of_sequence <= i_last;
                    if (!i_empty) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= ge ? CNT_W'(rem_sh - {1'b0, r_den}) : rem_sh[CNT_W-1:0];
                    r_num <= q;
                    r_bits <= r_bits - BIT_W'(1);
                    if (r_bits == '0) begin
                        o_smoothed <= r_neg ? (SAMPLE_W'(0) - q[SAMPLE_W-1:0])
                                            : q[SAMPLE_W-1:0];
                        r_state <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    if (!i_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: sv/edge_normalized_moving_average_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edge_normalized_moving_average_top
// Centered moving average over interleaved channels, edge-normalized.
// ----------------------------------------------------------------------------
// Input beats (i_valid/o_stall) carry one sample with its channel and an
// end-of-sequence flag; output beats (o_valid/i_stall) carry one smoothed
// value. The window length is written on the config port (always ready) and
// clears all channel state; write it only while the block is idle.
// The front works on one beat at a time and stalls until it is done, which
// covers trimming tail samples and queueing each result; it also stays
// stalled while the 4-entry job queue is full. The back pops one job, runs
// it through the bit-serial divider and holds the result on the output; it
// pops no new job until that result is taken. Results of a sample appear
// w-1-w/2 samples later; an end-of-sequence beat flushes all pending
// results of its channel.
// A stalled output holds its beat; the divider waits, the front keeps
// accepting until the queue fills. Reset is synchronous: job queue empty,
// window length 1, all channels empty. Samples on channels at or above
// CHANNELS are dropped.
// ----------------------------------------------------------------------------
module edge_normalized_moving_average_top
    import enma_pkg::*;
#(
    parameter int CHANNELS   = CHANNELS_DEF,
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic [CHAN_W-1:0]          i_channel,
    input  logic                       i_end_of_sequence,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic signed [SAMPLE_W-1:0] o_smoothed,
    output logic [CHAN_W-1:0]          o_out_channel,
    output logic                       o_last_of_sequence,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_W-1:0]           i_window_length
);

    localparam int TOT_W = SAMPLE_W + $clog2(MAX_WINDOW + 1);
    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int JOB_W = TOT_W + CNT_W + CHAN_W + 1;

    logic               push, full, pop, empty;
    logic [TOT_W-1:0]   f_sum, b_sum;
    logic [CNT_W-1:0]   f_cnt, b_cnt;
    logic [CHAN_W-1:0]  f_ch, b_ch;
    logic               f_last, b_last;

    assign o_cfg_ready = 1'b1;

    enma_front #(
        .CHANNELS   (CHANNELS),
        .MAX_WINDOW (MAX_WINDOW),
        .TOT_W      (TOT_W),
        .CNT_W      (CNT_W)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_sample          (i_sample),
        .i_channel         (i_channel),
        .i_end_of_sequence (i_end_of_sequence),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_data        (i_window_length),
        .o_push            (push),
        .o_job_sum         (f_sum),
        .o_job_count       (f_cnt),
        .o_job_channel     (f_ch),
        .o_job_last        (f_last),
        .i_full            (full)
    );

    enma_queue #(
        .WIDTH (JOB_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_sum, f_cnt, f_ch, f_last}),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  ({b_sum, b_cnt, b_ch, b_last}),
        .o_empty (empty)
    );

    enma_back #(
        .TOT_W (TOT_W),
        .CNT_W (CNT_W)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_empty            (empty),
        .o_pop              (pop),
        .i_sum              (b_sum),
        .i_count            (b_cnt),
        .i_channel          (b_ch),
        .i_last             (b_last),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_smoothed         (o_smoothed),
        .o_out_channel      (o_out_channel),
        .o_last_of_sequence (o_last_of_sequence)
    );

endmodule

FILE: sv/enma_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// enma_checker
// Port-level checks for the moving-average smoother, bound to the top level.
// ----------------------------------------------------------------------------
module enma_checker
    import enma_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_valid,
    input logic                       o_stall,
    input logic signed [SAMPLE_W-1:0] i_sample,
    input logic [CHAN_W-1:0]          i_channel,
    input logic                       i_end_of_sequence,
    input logic                       o_valid,
    input logic                       i_stall,
    input logic signed [SAMPLE_W-1:0] o_smoothed,
    input logic [CHAN_W-1:0]          o_out_channel,
    input logic                       o_last_of_sequence,
    input logic                       i_cfg_valid,
    input logic                       o_cfg_ready,
    input logic [CFG_W-1:0]           i_window_length
);

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("outputs active after reset");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (int'(i_channel) < CHANNELS) |=> o_stall)
        else $error("front took a beat without going busy");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("output beat dropped while stalled");

    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_smoothed) && $stable(o_out_channel)
                               && $stable(o_last_of_sequence))
        else $error("output payload changed while stalled");

endmodule

bind edge_normalized_moving_average_top enma_checker #(.CHANNELS(CHANNELS)) u_enma_checker (.*);

FILE: dv/tb_edge_normalized_moving_average_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_edge_normalized_moving_average_top
// Self-checking testbench for the centered moving-average smoother.
// ----------------------------------------------------------------------------
// Drives samples on interleaved channels and predicts every smoothed value
// with a per-channel ring of past samples and a running window sum, using
// edge-normalized rounded means. The output monitor compares each beat,
// in order, against the queue of predicted values. The window length is
// swept across its range, including the out-of-range codes, while the block
// is drained. Both sides idle and stall in short random bursts.
// ----------------------------------------------------------------------------
module tb_edge_normalized_moving_average_top;
    import enma_pkg::*;

    localparam int NCH     = CHANNELS_DEF;
    localparam int MAXW    = MAX_WINDOW_DEF;
    localparam int LIMIT   = 2000000;
    localparam int SETTLE  = 100;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] smoothed;
        logic [CHAN_W-1:0]          chan;
        logic                       last;
    } smooth_beat_t;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_valid;
    logic                       o_stall;
    logic signed [SAMPLE_W-1:0] i_sample;
    logic [CHAN_W-1:0]          i_channel;
    logic                       i_end_of_sequence;
    logic                       o_valid;
    logic                       i_stall;
    logic signed [SAMPLE_W-1:0] o_smoothed;
    logic [CHAN_W-1:0]          o_out_channel;
    logic                       o_last_of_sequence;
    logic                       i_cfg_valid;
    logic                       o_cfg_ready;
    logic [CFG_W-1:0]           i_window_length;

    edge_normalized_moving_average_top DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_sample           (i_sample),
        .i_channel          (i_channel),
        .i_end_of_sequence  (i_end_of_sequence),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_smoothed         (o_smoothed),
        .o_out_channel      (o_out_channel),
        .o_last_of_sequence (o_last_of_sequence),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_window_length    (i_window_length)
    );

    // predictor state
    logic signed [SAMPLE_W-1:0] hist_ring [NCH][MAXW];
    int                         win_sum   [NCH];
    int unsigned                wr_slot   [NCH];
    int unsigned                seen_cnt  [NCH];
    int unsigned                taps;

    smooth_beat_t pending_smooth[$];
    int           fail_count = 0;
    int           cycle_count = 0;
    bit           quiet;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!quiet && $urandom_range(0, 5) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        smooth_beat_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_smooth.size() == 0) begin
                $error("unexpected beat: smoothed %0d channel %0d", o_smoothed, o_out_channel);
                fail_count++;
            end else begin
                want = pending_smooth.pop_front();
                if (o_smoothed !== want.smoothed) begin
                    $error("smoothed: expected %0d, got %0d", want.smoothed, o_smoothed);
                    fail_count++;
                end
                if (o_out_channel !== want.chan) begin
                    $error("out_channel: expected %0d, got %0d", want.chan, o_out_channel);
                    fail_count++;
                end
                if (o_last_of_sequence !== want.last) begin
                    $error("last_of_sequence: expected %0d, got %0d",
                           want.last, o_last_of_sequence);
                    fail_count++;
                end
            end
        end
    end

    function automatic void clear_sequences();
        for (int c = 0; c < NCH; c++) begin
            win_sum[c]  = 0;
            wr_slot[c]  = 0;
            seen_cnt[c] = 0;
        end
    endfunction

    function automatic int unsigned ring_back(int unsigned cur, int unsigned back);
        return (cur + MAXW - (back % MAXW)) % MAXW;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] round_mean(int sum, int unsigned cnt);
        int unsigned mag;
        int unsigned q;
        mag = (sum < 0) ? -sum : sum;
        q   = (mag + cnt / 2) / cnt;
        return SAMPLE_W'((sum < 0) ? -q : q);
    endfunction

    function automatic void predict_smoothing(logic signed [SAMPLE_W-1:0] x,
                                              int unsigned c, bit eos);
        int unsigned half, lag, cur, seen, first, stop, cnt, target;
        int          total;
        smooth_beat_t b;
        half = taps / 2;
        lag  = taps - 1 - half;
        cur  = wr_slot[c];
        if (seen_cnt[c] >= taps)
            win_sum[c] -= hist_ring[c][ring_back(cur, taps)];
        win_sum[c] += x;
        hist_ring[c][cur] = x;
        seen = (seen_cnt[c] + 1 > MAXW) ? MAXW : seen_cnt[c] + 1;
        seen_cnt[c] = seen;
        wr_slot[c]  = (cur + 1) % MAXW;
        if (eos || lag < seen) begin
            first = (lag < seen) ? lag : seen - 1;
            stop  = eos ? 0 : lag;
            total = win_sum[c];
            cnt   = (seen < taps) ? seen : taps;
            for (int d = first; d >= int'(stop); d--) begin
                target = d + half + 1;
                if (target > seen) target = seen;
                while (cnt > target) begin
                    total -= hist_ring[c][ring_back(cur, cnt - 1)];
                    cnt--;
                end
                b.smoothed = round_mean(total, cnt);
                b.chan     = CHAN_W'(c);
                b.last     = eos && (d == 0);
                pending_smooth.push_back(b);
            end
        end
        if (eos) begin
            win_sum[c]  = 0;
            wr_slot[c]  = 0;
            seen_cnt[c] = 0;
        end
    endfunction

    task automatic send_sample(logic signed [SAMPLE_W-1:0] x, int unsigned c, bit eos);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_sample          <= x;
        i_channel         <= CHAN_W'(c);
        i_end_of_sequence <= eos;
        do @(posedge i_clk); while (o_stall);
        predict_smoothing(x, c, eos);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_smooth.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_window(logic [CFG_W-1:0] v);
        wait_drained();
        i_cfg_valid     <= 1'b1;
        i_window_length <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        taps = (v == 0) ? 1 : (v > MAXW) ? MAXW : v;
        clear_sequences();
    endtask

    task automatic send_sequence(int unsigned c, int unsigned len);
        for (int k = 0; k < len; k++)
            send_sample(SAMPLE_W'($urandom), c, k == len - 1);
    endtask

    task automatic test_extremes();
        send_sample(16'sh7FFF, 0, 0);
        send_sample(-16'sh8000, 1, 0);
        send_sample(16'sh0000, 2, 0);
        send_sample(16'shFFFF, 3, 1);
        send_sample(16'h5555, 0, 1);
        send_sample(16'hAAAA, 1, 1);
        write_window(CFG_W'(MAXW));
        for (int k = 0; k < 6; k++)
            send_sample((k % 2) ? -16'sh8000 : 16'sh7FFF, 2, k == 5);
        for (int k = 0; k < 4; k++)
            send_sample(-16'sh8000, 3, k == 3);
    endtask

    task automatic test_out_of_range_window();
        write_window(6'd0);
        send_sequence(1, 3);
        write_window(6'd63);
        send_sequence(0, 3);
        write_window(6'd33);
        send_sequence(2, 2);
    endtask

    task automatic test_short_and_ties();
        write_window(6'd4);
        send_sample(16'sd1, 0, 0);
        send_sample(16'sd2, 0, 1);
        send_sample(-16'sd1, 1, 0);
        send_sample(-16'sd2, 1, 1);
        send_sample(16'sd5, 2, 1);
    endtask

    task automatic test_drain_pause();
        write_window(6'd7);
        send_sequence(3, 9);
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_smooth.size() != 0);
        send_sequence(3, 5);
    endtask

    task automatic test_random_phase(logic [CFG_W-1:0] w, int unsigned items);
        int unsigned left [NCH];
        int unsigned c;
        write_window(w);
        for (int k = 0; k < NCH; k++) left[k] = $urandom_range(1, 45);
        for (int n = 0; n < items; n++) begin
            c = $urandom_range(0, NCH - 1);
            if ($urandom_range(0, 9) == 0) begin
                send_sample(SAMPLE_W'($urandom), c, 1);
                left[c] = $urandom_range(1, 45);
            end else begin
                left[c]--;
                send_sample(SAMPLE_W'($urandom), c, left[c] == 0);
                if (left[c] == 0) left[c] = $urandom_range(1, 45);
            end
        end
        for (int k = 0; k < NCH; k++) send_sample(SAMPLE_W'($urandom), k, 1);
    endtask

    initial begin
        i_rst_n           = 1'b0;
        i_valid           = 1'b0;
        i_sample          = '0;
        i_channel         = '0;
        i_end_of_sequence = 1'b0;
        i_cfg_valid       = 1'b0;
        i_window_length   = '0;
        quiet             = 0;
        taps              = 1;
        clear_sequences();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extremes();
        test_out_of_range_window();
        test_short_and_ties();
        test_drain_pause();
        test_random_phase(6'd1, 60);
        test_random_phase(6'd2, 60);
        test_random_phase(6'd5, 70);
        test_random_phase(CFG_W'(MAXW), 70);
        test_random_phase(CFG_W'($urandom_range(3, 31)), 70);
        quiet = 1;
        test_random_phase(CFG_W'($urandom_range(0, 63)), 70);

        wait_drained();
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
